// ===== hw/rtl/a2cb_pkg.sv =====
// ----------------------------------------------------------------------------
// a2cb_pkg: shared types and constants for the arc to cubic Bezier block
// Command format between front and back, CORDIC table, rounding helpers.
// ----------------------------------------------------------------------------
package a2cb_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int CMD_DEPTH      = 4;
  localparam int CORDIC_STEPS   = 22;

  localparam logic signed [17:0] TURN_S    = 18'sd65536;
  localparam logic signed [17:0] QUARTER_S = 18'sd16384;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [29:0]        KAPPA_Q30   = 30'd593011235;
  localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;

  // ceil(2^33 / 3): (n * RECIP3) >> 33 is n / 3 for any 32-bit n
  localparam logic [31:0]        RECIP3      = 32'hAAAAAAAB;

  typedef enum logic {
    CMD_SEG,
    CMD_QTR
  } cmd_kind_t;

  // One segment of work for the back end
  typedef struct packed {
    cmd_kind_t          kind;
    logic [15:0]        start;
    logic signed [15:0] sweep;
    logic [1:0]         quad;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        rx;
    logic [30:0]        ry;
    logic [3:0]         base;
    logic [2:0]         count;
    logic               last;
  } cmd_t;

  typedef enum logic {
    F_IDLE,
    F_GEN
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SETUP,
    B_KAPPA,
    B_QPT,
    B_CORD,
    B_DIV3,
    B_DIV3_WAIT,
    B_MULQ,
    B_DIVQ,
    B_DIVQ_WAIT,
    B_PT0,
    B_PT1,
    B_PT2,
    B_PT3,
    B_PT4
  } back_state_t;

  // Arctangent of 2^-i in 2^-24 turn units
  function automatic logic signed [23:0] atan_val(input logic [4:0] i);
    logic signed [23:0] a;
    a = '0;
    case (i)
      5'd0:  a = 24'sd2097152;
      5'd1:  a = 24'sd1238021;
      5'd2:  a = 24'sd654136;
      5'd3:  a = 24'sd332050;
      5'd4:  a = 24'sd166669;
      5'd5:  a = 24'sd83416;
      5'd6:  a = 24'sd41718;
      5'd7:  a = 24'sd20860;
      5'd8:  a = 24'sd10430;
      5'd9:  a = 24'sd5215;
      5'd10: a = 24'sd2608;
      5'd11: a = 24'sd1304;
      5'd12: a = 24'sd652;
      5'd13: a = 24'sd326;
      5'd14: a = 24'sd163;
      5'd15: a = 24'sd81;
      5'd16: a = 24'sd41;
      5'd17: a = 24'sd20;
      5'd18: a = 24'sd10;
      5'd19: a = 24'sd5;
      5'd20: a = 24'sd3;
      5'd21: a = 24'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round a Q30 product half up
  function automatic logic signed [71:0] rnd30(input logic signed [71:0] v);
    logic signed [71:0] t;
    t = v + 72'sd536870912;
    return t >>> 30;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/a2cb_cordic.sv =====
// ----------------------------------------------------------------------------
// a2cb_cordic: iterative rotation CORDIC
// Cosine and sine in Q2.30 of a 24-bit turn angle, one micro-rotation a cycle.
// ----------------------------------------------------------------------------
module a2cb_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [23:0]        angle,
  output logic               done,
  output logic signed [32:0] cos_q,
  output logic signed [32:0] sin_q
);

  logic signed [32:0] x, y;
  logic signed [23:0] z;
  logic [4:0]         step;
  logic [1:0]         quad;
  logic               run;
  logic signed [32:0] tx, ty;

  assign tx = y >>> step;
  assign ty = x >>> step;

  // Fold to +-1/8 turn around the nearest axis, then rotate
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        quad <= angle[23:22] + {1'b0, angle[21]};
        x    <= a2cb_pkg::CORDIC_GAIN;
        y    <= '0;
        z    <= {{2{angle[21]}}, angle[21:0]};
      end else if (run) begin
        if (!z[23]) begin
          x <= x - tx;
          y <= y + ty;
          z <= z - a2cb_pkg::atan_val(step);
        end else begin
          x <= x + tx;
          y <= y - ty;
          z <= z + a2cb_pkg::atan_val(step);
        end
        step <= step + 5'd1;
        if (step == 5'(a2cb_pkg::CORDIC_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Map back to the original quadrant
  always_comb begin
    case (quad)
      2'd0: begin
        cos_q = x;
        sin_q = y;
      end
      2'd1: begin
        cos_q = -y;
        sin_q = x;
      end
      2'd2: begin
        cos_q = -x;
        sin_q = -y;
      end
      default: begin
        cos_q = y;
        sin_q = -x;
      end
    endcase
  end

endmodule

// ===== hw/rtl/a2cb_div.sv =====
// ----------------------------------------------------------------------------
// a2cb_div: radix-2 restoring divider
// 64-bit by 32-bit unsigned, truncating, quotient saturates to 32 bits.
// ----------------------------------------------------------------------------
module a2cb_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] quo
);

  logic [31:0] rem;
  logic [31:0] lo;
  logic [4:0]  cnt;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem, lo[31]};
  assign ge    = trial >= {1'b0, den};
  assign quo   = lo;

  // One quotient bit a cycle; flag overflow up front
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num[63:32] >= den) begin
          lo   <= '1;
          done <= 1'b1;
        end else begin
          rem  <= num[63:32];
          lo   <= num[31:0];
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? 32'(trial - {1'b0, den}) : trial[31:0];
        lo  <= {lo[30:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/a2cb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// a2cb_cmd_fifo: segment command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module a2cb_cmd_fifo #(
  parameter int DEPTH = a2cb_pkg::CMD_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  a2cb_pkg::cmd_t  push_data,
  input  logic            pop,
  output a2cb_pkg::cmd_t  pop_data,
  output logic            full,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  a2cb_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  fill;

  assign full     = (fill == CW'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from empty queue");
`endif

endmodule

// ===== hw/rtl/a2cb_front.sv =====
// ----------------------------------------------------------------------------
// a2cb_front: arc classifier
// Accepts an arc, splits it into segment commands and queues them.
// ----------------------------------------------------------------------------
module a2cb_front #(
  parameter int MAX_POINTS = a2cb_pkg::MAX_POINTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [159:0]    s_axis_tdata,
  output logic            push,
  output a2cb_pkg::cmd_t  push_data,
  input  logic            full
);

  localparam int         LIMIT_I = ((MAX_POINTS - 1) / 3) * 3 + 1;
  localparam logic [4:0] LIMIT   = 5'((LIMIT_I > 16) ? 16 : LIMIT_I);

  a2cb_pkg::front_state_t state, state_next;

  // Input decode
  logic signed [31:0] in_cx, in_cy;
  logic [30:0]        in_rx, in_ry;
  logic [15:0]        in_st;
  logic signed [17:0] in_sw, sw_sat, rem;
  logic               drop, short_sw;
  logic [2:0]         j;
  logic [16:0]        axis, gap;
  logic [1:0]         in_nq;
  logic [13:0]        in_r;
  logic [2:0]         in_segs;
  logic [4:0]         in_n;
  logic               accept;

  // Held arc
  logic signed [31:0] cx, cy;
  logic [30:0]        rx, ry;
  logic [15:0]        st, axis_fin;
  logic signed [15:0] first_sw;
  logic [1:0]         q0, nq;
  logic [13:0]        r;
  logic [2:0]         segs, ci;
  logic [4:0]         lim, base;

  // Command build
  logic               is_final, more;
  logic [4:0]         remain, cnt_full;

  assign in_cx = $signed(s_axis_tdata[31:0]);
  assign in_cy = $signed(s_axis_tdata[63:32]);
  assign in_rx = s_axis_tdata[94:64];
  assign in_ry = s_axis_tdata[125:95];
  assign in_st = s_axis_tdata[141:126];
  assign in_sw = $signed(s_axis_tdata[159:142]);

  // Saturate the sweep and split it at the quadrant axes
  always_comb begin
    if (in_sw > a2cb_pkg::TURN_S) begin
      sw_sat = a2cb_pkg::TURN_S;
    end else if (in_sw < -a2cb_pkg::TURN_S) begin
      sw_sat = -a2cb_pkg::TURN_S;
    end else begin
      sw_sat = in_sw;
    end
    drop     = (in_rx == '0) || (sw_sat < -a2cb_pkg::QUARTER_S);
    short_sw = (sw_sat <= a2cb_pkg::QUARTER_S);
    j        = {1'b0, in_st[15:14]} + 3'd1;
    axis     = {j, 14'd0};
    gap      = axis - {1'b0, in_st};
    rem      = sw_sat - $signed({1'b0, gap});
    in_nq    = short_sw ? 2'd0 : rem[15:14];
    in_r     = short_sw ? 14'd0 : rem[13:0];
    in_segs  = 3'd1 + {1'b0, in_nq} + {2'b0, (in_r != '0)};
    in_n     = 5'({in_segs, 1'b0} + {2'b0, in_segs}) + 5'd1;
  end

  assign s_axis_tready = (state == a2cb_pkg::F_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Capture the arc description
  always_ff @(posedge clk) begin
    if (accept) begin
      cx       <= in_cx;
      cy       <= in_cy;
      rx       <= in_rx;
      ry       <= in_ry;
      st       <= in_st;
      first_sw <= short_sw ? sw_sat[15:0] : gap[15:0];
      q0       <= j[1:0];
      nq       <= in_nq;
      r        <= in_r;
      axis_fin <= axis[15:0] + {in_nq, 14'd0};
      segs     <= in_segs;
      lim      <= (in_n < LIMIT) ? in_n : LIMIT;
    end
  end

  // Build the command for segment ci
  always_comb begin
    is_final = (ci == segs - 3'd1);
    remain   = lim - base;
    cnt_full = is_final ? 5'd4 : 5'd3;
    push_data.cx    = cx;
    push_data.cy    = cy;
    push_data.rx    = rx;
    push_data.ry    = ry;
    push_data.quad  = q0 + ci[1:0] - 2'd1;
    push_data.base  = base[3:0];
    push_data.count = (remain < cnt_full) ? remain[2:0] : cnt_full[2:0];
    push_data.last  = (remain <= cnt_full);
    if (ci == 3'd0) begin
      push_data.kind  = a2cb_pkg::CMD_SEG;
      push_data.start = st;
      push_data.sweep = first_sw;
    end else if (ci == {1'b0, nq} + 3'd1) begin
      push_data.kind  = a2cb_pkg::CMD_SEG;
      push_data.start = axis_fin;
      push_data.sweep = $signed({2'b0, r});
    end else begin
      push_data.kind  = a2cb_pkg::CMD_QTR;
      push_data.start = st;
      push_data.sweep = '0;
    end
    more = (ci + 3'd1 < segs) && (base + 5'd3 < lim);
  end

  assign push = (state == a2cb_pkg::F_GEN) && !full;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      a2cb_pkg::F_IDLE: begin
        if (accept && !drop) begin
          state_next = a2cb_pkg::F_GEN;
        end
      end
      a2cb_pkg::F_GEN: begin
        if (push && !more) begin
          state_next = a2cb_pkg::F_IDLE;
        end
      end
      default: state_next = a2cb_pkg::F_IDLE;
    endcase
  end

  // State and segment counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= a2cb_pkg::F_IDLE;
      ci    <= '0;
      base  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        ci   <= '0;
        base <= '0;
      end else if (push) begin
        ci   <= ci + 3'd1;
        base <= base + 5'd3;
      end
    end
  end

endmodule

// ===== hw/rtl/a2cb_back.sv =====
// ----------------------------------------------------------------------------
// a2cb_back: segment evaluator
// Runs one command at a time: CORDIC, divides, rotation, scaling, output.
// ----------------------------------------------------------------------------
module a2cb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  output logic            pop,
  input  a2cb_pkg::cmd_t  pop_data,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [71:0]     m_axis_tdata,
  output logic            m_axis_tlast
);

  a2cb_pkg::back_state_t state, state_next;
  a2cb_pkg::cmd_t        cmd;

  logic signed [32:0] c, b, co, si;
  logic signed [33:0] x4;
  logic signed [32:0] y4;
  logic signed [71:0] m0, m1;
  logic signed [39:0] u, v;
  logic signed [31:0] px;
  logic [1:0]         pi;

  logic               cord_start, cdone_a, cdone_b;
  logic signed [32:0] cos_a, sin_a, cos_b, sin_b;
  logic [23:0]        half, rot;

  logic               div_start, div_busy, div_done;
  logic [63:0]        div_num;
  logic [31:0]        div_den, quo;

  logic signed [35:0] n4;
  logic               neg3;
  logic [31:0]        mag3;
  logic [32:0]        abs_b, abs_c, abs_x4;
  logic               sq;
  logic signed [35:0] qs, yraw;
  logic signed [35:0] ux, uy;
  logic signed [39:0] ox, oy;
  logic signed [31:0] dx, dy;
  logic signed [31:0] nx, ny;
  logic               out_free, load_out, end_pt;

  // Angles in 2^-24 turn: half sweep, and start plus half sweep
  assign half = {cmd.sweep[15], cmd.sweep, 7'd0};
  assign rot  = {cmd.start, 8'd0} + half;

  a2cb_cordic u_cord_half (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .angle (half),
    .done  (cdone_a),
    .cos_q (cos_a),
    .sin_q (sin_a)
  );

  a2cb_cordic u_cord_rot (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .angle (rot),
    .done  (cdone_b),
    .cos_q (cos_b),
    .sin_q (sin_b)
  );

  a2cb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  // Segment algebra helpers; the half sweep is within 1/8 turn, so
  // |4(1 - c)| stays below 2^31 and the divide by three fits 32 bits
  always_comb begin
    n4     = (a2cb_pkg::ONE_Q30 - 36'(c)) <<< 2;
    neg3   = n4[35];
    mag3   = (neg3 ? 32'(-n4) : 32'(n4)) + 32'd1;
    abs_b  = b[32] ? 33'(-b) : 33'(b);
    abs_c  = c[32] ? 33'(-c) : 33'(c);
    abs_x4 = x4[33] ? 33'(-x4) : 33'(x4);
    sq     = x4[33] ^ c[32] ^ b[32];
    qs     = sq ? -$signed({4'b0, quo}) : $signed({4'b0, quo});
    yraw   = 36'(b) - qs;
    dx     = 32'(a2cb_pkg::rnd30(m0));
    dy     = 32'(a2cb_pkg::rnd30(m1));
  end

  // Unit-circle point for the current index
  always_comb begin
    ux = ((pi == 2'd0) || (pi == 2'd3)) ? 36'(c) : 36'(c) + 36'(x4);
    case (pi)
      2'd0:    uy = -36'(b);
      2'd1:    uy = -36'(y4);
      2'd2:    uy = 36'(y4);
      default: uy = 36'(b);
    endcase
  end

  // Quarter offsets from the center
  always_comb begin
    ox = '0;
    oy = '0;
    case ({cmd.quad, pi})
      4'b00_00: begin ox =  40'(cmd.rx); oy = '0; end
      4'b00_01: begin ox =  40'(cmd.rx); oy =  40'(dy); end
      4'b00_10: begin ox =  40'(dx);     oy =  40'(cmd.ry); end
      4'b00_11: begin ox = '0;           oy =  40'(cmd.ry); end
      4'b01_00: begin ox = '0;           oy =  40'(cmd.ry); end
      4'b01_01: begin ox = -40'(dx);     oy =  40'(cmd.ry); end
      4'b01_10: begin ox = -40'(cmd.rx); oy =  40'(dy); end
      4'b01_11: begin ox = -40'(cmd.rx); oy = '0; end
      4'b10_00: begin ox = -40'(cmd.rx); oy = '0; end
      4'b10_01: begin ox = -40'(cmd.rx); oy = -40'(dy); end
      4'b10_10: begin ox = -40'(dx);     oy = -40'(cmd.ry); end
      4'b10_11: begin ox = '0;           oy = -40'(cmd.ry); end
      4'b11_00: begin ox = '0;           oy = -40'(cmd.ry); end
      4'b11_01: begin ox =  40'(dx);     oy = -40'(cmd.ry); end
      4'b11_10: begin ox =  40'(cmd.rx); oy = -40'(dy); end
      default:  begin ox =  40'(cmd.rx); oy = '0; end
    endcase
  end

  // Point going to the output register
  always_comb begin
    if (state == a2cb_pkg::B_QPT) begin
      nx = a2cb_pkg::sat32(40'(cmd.cx) + ox);
      ny = a2cb_pkg::sat32(40'(cmd.cy) + oy);
    end else begin
      nx = px;
      ny = a2cb_pkg::sat32(40'(cmd.cy) + 40'(a2cb_pkg::rnd30(m1)));
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign end_pt   = ({1'b0, pi} == cmd.count - 3'd1);

  // Control outputs
  always_comb begin
    pop        = (state == a2cb_pkg::B_IDLE) && !empty;
    cord_start = (state == a2cb_pkg::B_SETUP) && (cmd.kind == a2cb_pkg::CMD_SEG);
    div_start  = (state == a2cb_pkg::B_DIVQ) && (b != '0);
    div_num    = m0[63:0];
    div_den    = abs_b[31:0];
    load_out   = ((state == a2cb_pkg::B_QPT) || (state == a2cb_pkg::B_PT4)) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      a2cb_pkg::B_IDLE:      if (!empty) state_next = a2cb_pkg::B_SETUP;
      a2cb_pkg::B_SETUP: begin
        state_next = (cmd.kind == a2cb_pkg::CMD_SEG) ? a2cb_pkg::B_CORD : a2cb_pkg::B_KAPPA;
      end
      a2cb_pkg::B_KAPPA:     state_next = a2cb_pkg::B_QPT;
      a2cb_pkg::B_QPT:       if (load_out && end_pt) state_next = a2cb_pkg::B_IDLE;
      a2cb_pkg::B_CORD:      if (cdone_a) state_next = a2cb_pkg::B_DIV3;
      a2cb_pkg::B_DIV3:      state_next = a2cb_pkg::B_DIV3_WAIT;
      a2cb_pkg::B_DIV3_WAIT: state_next = a2cb_pkg::B_MULQ;
      a2cb_pkg::B_MULQ:      state_next = a2cb_pkg::B_DIVQ;
      a2cb_pkg::B_DIVQ: begin
        state_next = (b == '0) ? a2cb_pkg::B_PT0 : a2cb_pkg::B_DIVQ_WAIT;
      end
      a2cb_pkg::B_DIVQ_WAIT: if (div_done) state_next = a2cb_pkg::B_PT0;
      a2cb_pkg::B_PT0:       state_next = a2cb_pkg::B_PT1;
      a2cb_pkg::B_PT1:       state_next = a2cb_pkg::B_PT2;
      a2cb_pkg::B_PT2:       state_next = a2cb_pkg::B_PT3;
      a2cb_pkg::B_PT3:       state_next = a2cb_pkg::B_PT4;
      a2cb_pkg::B_PT4: begin
        if (load_out) begin
          state_next = end_pt ? a2cb_pkg::B_IDLE : a2cb_pkg::B_PT0;
        end
      end
      default:               state_next = a2cb_pkg::B_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= a2cb_pkg::B_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= pop_data;
    end
    if (state == a2cb_pkg::B_SETUP) begin
      pi <= '0;
    end else if (load_out) begin
      pi <= pi + 2'd1;
    end
    if (load_out) begin
      m_axis_tdata <= {4'd0, cmd.base + {2'b0, pi}, ny, nx};
      m_axis_tlast <= cmd.last && end_pt;
    end
    case (state)
      a2cb_pkg::B_KAPPA: begin
        m0 <= $signed({11'd0, 61'(cmd.rx * a2cb_pkg::KAPPA_Q30)});
        m1 <= $signed({11'd0, 61'(cmd.ry * a2cb_pkg::KAPPA_Q30)});
      end
      a2cb_pkg::B_CORD: begin
        if (cdone_a) begin
          c  <= cos_a;
          b  <= sin_a;
          co <= cos_b;
          si <= sin_b;
        end
      end
      // Divide by three through the reciprocal, product then shift
      a2cb_pkg::B_DIV3: begin
        m0 <= $signed({8'd0, 64'(mag3 * a2cb_pkg::RECIP3)});
      end
      a2cb_pkg::B_DIV3_WAIT: begin
        x4 <= neg3 ? -$signed({3'b0, m0[63:33]}) : $signed({3'b0, m0[63:33]});
      end
      a2cb_pkg::B_MULQ: begin
        m0 <= $signed({6'd0, 66'(abs_x4 * abs_c)});
      end
      a2cb_pkg::B_DIVQ: begin
        if (b == '0) begin
          y4 <= '0;
        end
      end
      a2cb_pkg::B_DIVQ_WAIT: begin
        if (div_done) begin
          if (!b[32]) begin
            if (yraw < 0) begin
              y4 <= '0;
            end else if (yraw > 36'(b)) begin
              y4 <= b;
            end else begin
              y4 <= yraw[32:0];
            end
          end else begin
            if (yraw > 0) begin
              y4 <= '0;
            end else if (yraw < 36'(b)) begin
              y4 <= b;
            end else begin
              y4 <= yraw[32:0];
            end
          end
        end
      end
      a2cb_pkg::B_PT0: begin
        m0 <= 72'(ux * co);
        m1 <= 72'(uy * si);
      end
      a2cb_pkg::B_PT1: begin
        u  <= 40'(a2cb_pkg::rnd30(m0 - m1));
        m0 <= 72'(ux * si);
        m1 <= 72'(uy * co);
      end
      a2cb_pkg::B_PT2: begin
        v  <= 40'(a2cb_pkg::rnd30(m0 + m1));
        m0 <= 72'($signed({1'b0, cmd.rx}) * u);
      end
      a2cb_pkg::B_PT3: begin
        m1 <= 72'($signed({1'b0, cmd.ry}) * v);
        px <= a2cb_pkg::sat32(40'(cmd.cx) + 40'(a2cb_pkg::rnd30(m0)));
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cordic_lockstep: assert property (@(posedge clk) disable iff (rst)
    cdone_a == cdone_b)
    else $error("CORDIC units out of step");
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !load_out)
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== hw/rtl/arc_to_cubic_bezier.sv =====
// ----------------------------------------------------------------------------
// arc_to_cubic_bezier: elliptical arc to cubic Bezier control points
// Front end splits arcs into segment commands; back end evaluates them.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  s_axis   | in  | tdata[159:0]: center_x, center_y, radius_x, radius_y,
//           |     |               start_angle, sweep_angle
//  m_axis   | out | tdata[71:0]: point_x, point_y, point_index; tlast=last_point
//
// A curve segment in the back end takes two parallel 22-step CORDIC runs, a
// reciprocal multiply for the divide by three, one 32-step division and the
// point states B_PT0 to B_PT4 for each point. A quarter segment skips these
// and goes from B_KAPPA to B_QPT. The front end takes the next arc once its
// commands are queued; a stalled output holds the back end. Synchronous
// reset, no clearing pass.
// ----------------------------------------------------------------------------
module arc_to_cubic_bezier #(
  parameter int MAX_POINTS = a2cb_pkg::MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_x[31:0], center_y[63:32], radius_x[94:64], radius_y[125:95],
  // start_angle[141:126], sweep_angle[159:142]
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // point_x[31:0], point_y[63:32], point_index[67:64], zero[71:68]
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  logic           push, pop, full, empty;
  a2cb_pkg::cmd_t push_data, pop_data;

  a2cb_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  a2cb_cmd_fifo #(
    .DEPTH (a2cb_pkg::CMD_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  a2cb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .pop           (pop),
    .pop_data      (pop_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for arc_to_cubic_bezier
// Streams elliptical arcs into the block and computes in parallel the Bezier
// control points that each arc should produce. Every emitted point is checked
// in order against that list, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     QTR    = 16384;
  localparam int     FULL   = 65536;
  localparam longint GAIN   = 652032874;
  localparam longint KAPPA  = 593011235;
  localparam longint UNITY  = 64'sd1 << 30;
  localparam longint HALF30 = 64'sd1 << 29;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [3:0]  idx;
    logic        last;
  } ctrl_point_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;
  logic         m_axis_tlast;

  logic [159:0] arc_queue[$];
  ctrl_point_t  point_queue[$];
  longint       seg_x[16];
  longint       seg_y[16];
  int           send_idle;
  int           recv_idle;
  int           errors;
  int           arcs_sent;
  int           points_seen;
  logic         hold_req;
  logic         hold_taken;
  int           hold_left;

  arc_to_cubic_bezier dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  function automatic longint atan_step(input int i);
    longint t[22] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                      20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
                      10, 5, 3, 1};
    return t[i];
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + HALF30) >>> 30;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Sine and cosine in Q30 of an angle in 2^-24 turn units
  function automatic void sin_cos(input logic [23:0] ang, output longint co,
                                  output longint si);
    logic [1:0] quad;
    longint     r, x, y, z, tx, ty;
    quad = ang[23:22];
    r = longint'(ang[21:0]);
    if (r >= 64'h200000) begin
      r = r - 64'h400000;
      quad = quad + 2'd1;
    end
    x = GAIN;
    y = 0;
    z = r;
    for (int i = 0; i < 22; i++) begin
      tx = y >>> i;
      ty = x >>> i;
      if (z >= 0) begin
        x = x - tx; y = y + ty; z = z - atan_step(i);
      end else begin
        x = x + tx; y = y - ty; z = z + atan_step(i);
      end
    end
    case (quad)
      2'd0: begin co = x;  si = y;  end
      2'd1: begin co = -y; si = x;  end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  // Four control points of one curve segment, written from index base
  function automatic void curve_segment(input int base, input longint cx, cy, rx,
                                        ry, start, sw);
    longint      c, b, co, si, x4, y4, num, u, v;
    longint      ux[4];
    longint      uy[4];
    logic [31:0] rot;
    sin_cos(24'(sw * 128), c, b);
    num = (UNITY - c) * 4;
    if (num >= 0) x4 = (num + 1) / 3;
    else x4 = -((-num + 1) / 3);
    if (b == 0) begin
      y4 = 0;
    end else begin
      y4 = b - (x4 * c) / b;
      if (b > 0) begin
        if (y4 < 0) y4 = 0;
        if (y4 > b) y4 = b;
      end else begin
        if (y4 > 0) y4 = 0;
        if (y4 < b) y4 = b;
      end
    end
    ux[0] = c;      uy[0] = -b;
    ux[1] = c + x4; uy[1] = -y4;
    ux[2] = c + x4; uy[2] = y4;
    ux[3] = c;      uy[3] = b;
    rot = (32'(start) << 8) + 32'(sw * 128);
    sin_cos(rot[23:0], co, si);
    for (int i = 0; i < 4; i++) begin
      u = round_q30(ux[i] * co - uy[i] * si);
      v = round_q30(ux[i] * si + uy[i] * co);
      seg_x[(base + i) & 15] = clamp32(cx + round_q30(rx * u));
      seg_y[(base + i) & 15] = clamp32(cy + round_q30(ry * v));
    end
  endfunction

  function automatic void put_point(input int i, input longint x, y);
    seg_x[i & 15] = clamp32(x);
    seg_y[i & 15] = clamp32(y);
  endfunction

  // Quarter segment on the axes, quadrant k counted from +X
  function automatic void axis_quarter(input int base, input int k,
                                       input longint cx, cy, rx, ry, dx, dy);
    case (k & 3)
      0: begin
        put_point(base, cx + rx, cy);          put_point(base + 1, cx + rx, cy + dy);
        put_point(base + 2, cx + dx, cy + ry); put_point(base + 3, cx, cy + ry);
      end
      1: begin
        put_point(base, cx, cy + ry);          put_point(base + 1, cx - dx, cy + ry);
        put_point(base + 2, cx - rx, cy + dy); put_point(base + 3, cx - rx, cy);
      end
      2: begin
        put_point(base, cx - rx, cy);          put_point(base + 1, cx - rx, cy - dy);
        put_point(base + 2, cx - dx, cy - ry); put_point(base + 3, cx, cy - ry);
      end
      default: begin
        put_point(base, cx, cy - ry);          put_point(base + 1, cx + dx, cy - ry);
        put_point(base + 2, cx + rx, cy - dy); put_point(base + 3, cx + rx, cy);
      end
    endcase
  endfunction

  // Queue the control points that one arc should produce
  function automatic void predict_points(input logic [159:0] d);
    longint      cx, cy, rx, ry, st, sw, j, axis, gap, rem, dx, dy;
    int          n, k;
    ctrl_point_t p;
    cx = longint'($signed(d[31:0]));
    cy = longint'($signed(d[63:32]));
    rx = longint'(d[94:64]);
    ry = longint'(d[125:95]);
    st = longint'(d[141:126]);
    sw = longint'($signed(d[159:142]));
    n = 0;
    if (sw > FULL) sw = FULL;
    if (sw < -FULL) sw = -FULL;
    if (rx == 0) return;
    if (sw >= -QTR && sw <= QTR) begin
      curve_segment(0, cx, cy, rx, ry, st, sw);
      n = 4;
    end else if (sw > 0) begin
      j = st / QTR + 1;
      axis = j * QTR;
      gap = axis - st;
      rem = sw - gap;
      dx = (rx * KAPPA + HALF30) >>> 30;
      dy = (ry * KAPPA + HALF30) >>> 30;
      k = int'(j & 3);
      curve_segment(0, cx, cy, rx, ry, st, gap);
      n = 4;
      while (rem >= QTR && n + 3 <= 16) begin
        axis_quarter(n - 1, k, cx, cy, rx, ry, dx, dy);
        k = (k + 1) & 3;
        n += 3;
        rem -= QTR;
        axis += QTR;
      end
      if (rem > 0 && n + 3 <= 16) begin
        curve_segment(n - 1, cx, cy, rx, ry, axis, rem);
        n += 3;
      end
    end
    for (int i = 0; i < n; i++) begin
      p.px = seg_x[i][31:0];
      p.py = seg_y[i][31:0];
      p.idx = 4'(i);
      p.last = (i == n - 1);
      point_queue.push_back(p);
    end
  endfunction

  function automatic logic [159:0] pack_arc(input logic [31:0] cx, cy,
                                            input logic [30:0] rx, ry,
                                            input logic [15:0] st,
                                            input logic [17:0] sw);
    return {sw, st, ry, rx, cy, cx};
  endfunction

  // Random arc, mostly well-formed with moderate sizes
  function automatic logic [159:0] random_arc();
    logic [31:0] cx, cy;
    logic [30:0] rx, ry;
    logic [15:0] st;
    logic [17:0] sw;
    int          pick;
    pick = $urandom_range(99);
    cx = (pick < 25) ? $urandom : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    cy = (pick > 75) ? $urandom : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    rx = ($urandom_range(9) < 2) ? 31'($urandom) : 31'($urandom_range(0, 1 << 24));
    ry = ($urandom_range(9) < 2) ? 31'($urandom) : 31'($urandom_range(0, 1 << 24));
    if ($urandom_range(39) == 0) rx = '0;
    if ($urandom_range(39) == 0) ry = '0;
    st = ($urandom_range(7) == 0) ? 16'(QTR * $urandom_range(3)) : 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) sw = 18'($signed($urandom_range(0, 2 * QTR)) - QTR);
    else if (pick < 80) sw = 18'($urandom_range(QTR + 1, FULL));
    else if (pick < 90) sw = 18'(-$signed($urandom_range(QTR + 1, FULL)));
    else sw = 18'($urandom);
    return pack_arc(cx, cy, rx, ry, st, sw);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive input arcs from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (arc_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tdata <= arc_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the output at random, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_taken <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 2000;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= (hold_left == 1);
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    ctrl_point_t want;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      arcs_sent <= arcs_sent + 1;
      predict_points(s_axis_tdata);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      points_seen <= points_seen + 1;
      if (point_queue.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h idx=%0d last=%b", $realtime,
                 m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[67:64],
                 m_axis_tlast);
        errors <= errors + 1;
      end else begin
        want = point_queue.pop_front();
        if (m_axis_tdata[31:0] !== want.px || m_axis_tdata[63:32] !== want.py ||
            m_axis_tdata[67:64] !== want.idx || m_axis_tdata[71:68] !== 4'd0 ||
            m_axis_tlast !== want.last) begin
          $display("%0t: point mismatch expected x=%h y=%h idx=%0d last=%b",
                   $realtime, want.px, want.py, want.idx, want.last);
          $display("%0t:                actual x=%h y=%h idx=%0d last=%b pad=%h",
                   $realtime, m_axis_tdata[31:0], m_axis_tdata[63:32],
                   m_axis_tdata[67:64], m_axis_tlast, m_axis_tdata[71:68]);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (arc_queue.size() > 0 || s_axis_tvalid || point_queue.size() > 0);
    repeat (400) @(posedge clk);
  endtask

  // Stimulus: directed arcs, then three random phases with different stalls
  initial begin
    rst = 1'b1;
    hold_req = 1'b0;
    errors = 0;
    arcs_sent = 0;
    points_seen = 0;
    send_idle = 20;
    recv_idle = 86;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    arc_queue.push_back(pack_arc(0, 0, 31'h10000, 31'h10000, 0, 18'(QTR)));
    arc_queue.push_back(pack_arc(0, 0, 31'h10000, 31'h20000, 100, 0));
    arc_queue.push_back(pack_arc(0, 0, 31'h10000, 31'h10000, 0, 18'(-QTR)));
    arc_queue.push_back(pack_arc(0, 0, 31'h10000, 31'h10000, 0, 18'(-QTR - 1)));
    arc_queue.push_back(pack_arc(0, 0, 0, 31'h10000, 0, 18'(FULL)));
    arc_queue.push_back(pack_arc(0, 0, 31'h30000, 31'h20000, 0, 18'(FULL)));
    arc_queue.push_back(pack_arc(5, 7, 31'h30000, 31'h20000, 16'hFFFF, 18'h1FFFF));
    arc_queue.push_back(pack_arc(1, 2, 31'h10000, 31'h10000, 16'(QTR), 18'h20000));
    arc_queue.push_back(pack_arc(0, 0, 31'h10000, 31'h10000, 16'(3 * QTR), 18'(QTR + 1)));
    arc_queue.push_back(pack_arc(0, 0, 31'h10000, 0, 16'(1000), 18'(40000)));
    arc_queue.push_back(pack_arc(32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                                 31'h7FFFFFFF, 16'(5000), 18'(FULL)));
    arc_queue.push_back(pack_arc(32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                                 31'h7FFFFFFF, 16'(20000), 18'(50000)));
    arc_queue.push_back(pack_arc(32'hFFFF0000, 32'h00010000, 31'h1, 31'h1,
                                 16'(12345), 18'(30000)));
    arc_queue.push_back(pack_arc(0, 0, 31'h40000, 31'h10000, 16'(QTR - 1), 18'(2 * QTR)));
    arc_queue.push_back(pack_arc(0, 0, 31'h40000, 31'h10000, 16'(2 * QTR), 18'(1)));
    arc_queue.push_back(pack_arc(0, 0, 31'h40000, 31'h10000, 16'(777), 18'(-1)));
    wait_drained();

    for (int i = 0; i < 150; i++) arc_queue.push_back(random_arc());
    wait_drained();

    send_idle = 86;
    recv_idle = 20;
    for (int i = 0; i < 150; i++) arc_queue.push_back(random_arc());
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 150; i++) arc_queue.push_back(random_arc());
    wait_drained();

    $display("Run covered %0d arcs (short, multi-quadrant, negative, zero radius,",
             arcs_sent);
    $display("saturating) and checked %0d control points.", points_seen);
    if (errors == 0 && point_queue.size() == 0) begin
      $display("arc_to_cubic_bezier test passed");
    end else begin
      $display("arc_to_cubic_bezier test failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("arc_to_cubic_bezier test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/a2cb_pkg.sv
hw/rtl/a2cb_cordic.sv
hw/rtl/a2cb_div.sv
hw/rtl/a2cb_cmd_fifo.sv
hw/rtl/a2cb_front.sv
hw/rtl/a2cb_back.sv
hw/rtl/arc_to_cubic_bezier.sv
bench/tb_top.sv
